>>> design/necird_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Shared widths, codes and transaction types of the decoder.
// ----------------------------------------------------------------------------
package necird_pkg;

  // Field widths
  localparam int unsigned TickW    = 15;            // receiver tick count
  localparam int unsigned DivW     = 8;             // ticks per 10 us
  localparam int unsigned MarginW  = 10;            // tolerance, per mille
  localparam int unsigned TimeW    = 15;            // target time in us
  localparam int unsigned FieldW   = 16;            // address/command/extra
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  // Duration in us: (ticks * 10) / div, all ones when div is zero
  localparam int unsigned UsW      = 19;
  localparam int unsigned DivCntW  = $clog2(UsW);

  // Window arithmetic: 1000 * us against target * (1000 +/- margin)
  localparam int unsigned Mille    = 1000;
  localparam int unsigned FactorW  = 11;
  localparam int unsigned ProdW    = TimeW + FactorW;
  localparam int unsigned ScaledW  = UsW + 10;

  // Burst bookkeeping
  localparam int unsigned MaxPairs  = 63;
  localparam int unsigned PairCntW  = $clog2(MaxPairs + 1);
  localparam int unsigned ShiftW    = 48;
  localparam int unsigned ShiftIdxW = $clog2(ShiftW);
  localparam int unsigned RepeatLen = 2;
  localparam int unsigned FrameLen  = 34;
  localparam int unsigned ExtLen    = 50;

  // Window checks run per pulse pair, two products each
  localparam int unsigned NumChecks = 6;
  localparam int unsigned ChkW      = $clog2(NumChecks);
  localparam int unsigned NumSteps  = 2 * NumChecks;
  localparam int unsigned StepW     = $clog2(NumSteps + 1);

  // Queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTicks     = 3'd0,
    CfgMargin    = 3'd1,
    CfgBitMark   = 3'd2,
    CfgOneSpace  = 3'd3,
    CfgZeroSpace = 3'd4,
    CfgRepMark   = 3'd5,
    CfgRepSpace  = 3'd6,
    CfgRepTail   = 3'd7
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    StRepeat       = 3'd0,
    StFrame        = 3'd1,
    StExtFrame     = 3'd2,
    StRepLevelErr  = 3'd3,
    StRepTimingErr = 3'd4,
    StBitErr       = 3'd5,
    StBadLength    = 3'd6
  } status_e;

  typedef enum logic [ChkW-1:0] {
    ChkRepMark   = 3'd0,
    ChkRepSpace  = 3'd1,
    ChkRepTail   = 3'd2,
    ChkBitMark   = 3'd3,
    ChkOneSpace  = 3'd4,
    ChkZeroSpace = 3'd5
  } chk_e;

  typedef struct packed {
    logic             mark_level;
    logic [TickW-1:0] mark_ticks;
    logic             space_level;
    logic [TickW-1:0] space_ticks;
    logic             burst_end;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FieldW-1:0]  address;
    logic [FieldW-1:0]  command;
    logic [FieldW-1:0]  extra;
  } out_item_t;

  // Pulse pair after tick conversion
  typedef struct packed {
    logic           mark_level;
    logic [UsW-1:0] mark_us;
    logic           space_level;
    logic [UsW-1:0] space_us;
    logic           burst_end;
  } pair_t;

  typedef struct packed {
    logic [DivW-1:0]    ticks_per_10us;
    logic [MarginW-1:0] margin_per_mille;
    logic [TimeW-1:0]   bit_mark_us;
    logic [TimeW-1:0]   one_space_us;
    logic [TimeW-1:0]   zero_space_us;
    logic [TimeW-1:0]   repeat_mark_us;
    logic [TimeW-1:0]   repeat_space_us;
    logic [TimeW-1:0]   repeat_tail_us;
  } cfg_t;

endpackage

>>> design/necird_front.sv
// ----------------------------------------------------------------------------
// NEC IR decoder front end
// Accepts pulse pairs and converts both durations from ticks to us.
// ----------------------------------------------------------------------------
module necird_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  necird_pkg::in_item_t             in_item_i,
  input  logic [necird_pkg::DivW-1:0]      divisor_i,
  output logic                             push_o,
  output necird_pkg::pair_t                push_data_o,
  input  logic                             full_i
);

  typedef enum logic [2:0] {
    FIdle = 3'b001,
    FDiv  = 3'b010,
    FPush = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;
  logic [necird_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [necird_pkg::DivW-1:0]    div_q, div_d;
  logic [necird_pkg::UsW-1:0]     mark_num_q, mark_num_d, space_num_q, space_num_d;
  logic [necird_pkg::UsW-1:0]     mark_quo_q, mark_quo_d, space_quo_q, space_quo_d;
  logic [necird_pkg::DivW-1:0]    mark_rem_q, mark_rem_d, space_rem_q, space_rem_d;
  logic                           ml_q, ml_d, sl_q, sl_d, last_q, last_d;

  logic [necird_pkg::DivW:0] mark_trial, space_trial, div_ext;
  logic                      mark_ge, space_ge;

  // One restoring step per cycle on both halves; a zero divisor yields all ones
  assign div_ext     = {1'b0, div_q};
  assign mark_trial  = {mark_rem_q, mark_num_q[necird_pkg::UsW-1]};
  assign space_trial = {space_rem_q, space_num_q[necird_pkg::UsW-1]};
  assign mark_ge     = mark_trial >= div_ext;
  assign space_ge    = space_trial >= div_ext;

  assign in_ready_o = (state_q == FIdle);
  assign push_o     = (state_q == FPush) && !full_i;

  always_comb begin
    push_data_o             = '0;
    push_data_o.mark_level  = ml_q;
    push_data_o.mark_us     = mark_quo_q;
    push_data_o.space_level = sl_q;
    push_data_o.space_us    = space_quo_q;
    push_data_o.burst_end   = last_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    div_d       = div_q;
    mark_num_d  = mark_num_q;
    space_num_d = space_num_q;
    mark_quo_d  = mark_quo_q;
    space_quo_d = space_quo_q;
    mark_rem_d  = mark_rem_q;
    space_rem_d = space_rem_q;
    ml_d        = ml_q;
    sl_d        = sl_q;
    last_d      = last_q;
    case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          // ticks * 10 = ticks * 8 + ticks * 2
          mark_num_d  = necird_pkg::UsW'({in_item_i.mark_ticks, 3'b000})
                      + necird_pkg::UsW'({in_item_i.mark_ticks, 1'b0});
          space_num_d = necird_pkg::UsW'({in_item_i.space_ticks, 3'b000})
                      + necird_pkg::UsW'({in_item_i.space_ticks, 1'b0});
          mark_rem_d  = '0;
          space_rem_d = '0;
          mark_quo_d  = '0;
          space_quo_d = '0;
          cnt_d       = '0;
          div_d       = divisor_i;
          ml_d        = in_item_i.mark_level;
          sl_d        = in_item_i.space_level;
          last_d      = in_item_i.burst_end;
          state_d     = FDiv;
        end
      end
      FDiv: begin
        mark_num_d  = {mark_num_q[necird_pkg::UsW-2:0], 1'b0};
        space_num_d = {space_num_q[necird_pkg::UsW-2:0], 1'b0};
        mark_quo_d  = {mark_quo_q[necird_pkg::UsW-2:0], mark_ge};
        space_quo_d = {space_quo_q[necird_pkg::UsW-2:0], space_ge};
        mark_rem_d  = mark_ge ? necird_pkg::DivW'(mark_trial - div_ext)
                              : necird_pkg::DivW'(mark_trial);
        space_rem_d = space_ge ? necird_pkg::DivW'(space_trial - div_ext)
                               : necird_pkg::DivW'(space_trial);
        cnt_d       = cnt_q + necird_pkg::DivCntW'(1);
        if (cnt_q == necird_pkg::DivCntW'(necird_pkg::UsW - 1)) begin
          state_d = FPush;
        end
      end
      FPush: begin
        if (!full_i) begin
          state_d = FIdle;
        end
      end
      default: begin
        state_d = FIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q       <= div_d;
    mark_num_q  <= mark_num_d;
    space_num_q <= space_num_d;
    mark_quo_q  <= mark_quo_d;
    space_quo_q <= space_quo_d;
    mark_rem_q  <= mark_rem_d;
    space_rem_q <= space_rem_d;
    ml_q        <= ml_d;
    sl_q        <= sl_d;
    last_q      <= last_d;
  end

endmodule

>>> design/necird_fifo.sv
// ----------------------------------------------------------------------------
// NEC IR decoder pair queue
// Short queue of converted pulse pairs between front and back end.
// ----------------------------------------------------------------------------
module necird_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  necird_pkg::pair_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output necird_pkg::pair_t pop_data_o,
  output logic              empty_o
);

  necird_pkg::pair_t entries_q [necird_pkg::QDepth];
  logic [necird_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [necird_pkg::QCntW-1:0] count_q;

  assign full_o     = (count_q == necird_pkg::QCntW'(necird_pkg::QDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == necird_pkg::QPtrW'(necird_pkg::QDepth - 1))
                  ? '0 : wr_ptr_q + necird_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == necird_pkg::QPtrW'(necird_pkg::QDepth - 1))
                  ? '0 : rd_ptr_q + necird_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + necird_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - necird_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("pair queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pair queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= necird_pkg::QCntW'(necird_pkg::QDepth))
    else $error("pair queue count out of range");
`endif

endmodule

>>> design/necird_back.sv
// ----------------------------------------------------------------------------
// NEC IR decoder back end
// Window checks on one shared multiplier, burst state and result register.
// ----------------------------------------------------------------------------
module necird_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  necird_pkg::cfg_t     cfg_i,
  input  logic                 empty_i,
  input  necird_pkg::pair_t    pop_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output necird_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    BIdle = 3'b001,
    BCalc = 3'b010,
    BDone = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  necird_pkg::pair_t pair_q, pair_d;
  logic [necird_pkg::ScaledW-1:0]   mark_k_q, mark_k_d, space_k_q, space_k_d;
  logic [necird_pkg::StepW-1:0]     step_q, step_d;
  logic [necird_pkg::ProdW-1:0]     prod_q, prod_d;
  logic [necird_pkg::NumChecks-1:0] win_q, win_d;

  logic [necird_pkg::PairCntW-1:0] pair_count_q, pair_count_d;
  logic [necird_pkg::ShiftW-1:0]   bit_shift_q, bit_shift_d;
  logic bit_err_q, bit_err_d, hi_err_q, hi_err_d;
  logic rep_level_bad_q, rep_level_bad_d, rep_timing_bad_q, rep_timing_bad_d;

  logic                  out_valid_q, out_valid_d;
  necird_pkg::out_item_t out_item_q, out_item_d;

  // Multiply/compare datapath
  logic [necird_pkg::ChkW-1:0]    cur_chk, prev_chk;
  logic [necird_pkg::StepW-1:0]   prev_step;
  logic [necird_pkg::TimeW-1:0]   target;
  logic [necird_pkg::FactorW-1:0] factor;
  logic [necird_pkg::ScaledW-1:0] scaled_sel, prod_ext;
  logic                           margin_wide, cmp_ok;

  // Pair resolution
  logic [necird_pkg::PairCntW-1:0] idx;
  logic [necird_pkg::ShiftIdxW-1:0] bit_idx;
  logic                            is_one, is_bit, tail_bad, commit;
  logic [necird_pkg::PairCntW-1:0] cnt_upd;
  logic [necird_pkg::ShiftW-1:0]   shift_upd;
  logic bit_err_upd, hi_err_upd, rlb_upd, rtb_upd;
  necird_pkg::out_item_t result;

  function automatic logic [necird_pkg::ScaledW-1:0] times_mille(
    input logic [necird_pkg::UsW-1:0] us
  );
    // us * 1000 = us * 1024 - us * 16 - us * 8
    return necird_pkg::ScaledW'({us, 10'b0})
         - necird_pkg::ScaledW'({us, 4'b0})
         - necird_pkg::ScaledW'({us, 3'b0});
  endfunction

  assign cur_chk     = necird_pkg::ChkW'(step_q[necird_pkg::StepW-1:1]);
  assign prev_step   = step_q - necird_pkg::StepW'(1);
  assign prev_chk    = necird_pkg::ChkW'(prev_step[necird_pkg::StepW-1:1]);
  assign margin_wide = cfg_i.margin_per_mille > necird_pkg::MarginW'(necird_pkg::Mille);

  always_comb begin
    case (necird_pkg::chk_e'(cur_chk))
      necird_pkg::ChkRepMark:   target = cfg_i.repeat_mark_us;
      necird_pkg::ChkRepSpace:  target = cfg_i.repeat_space_us;
      necird_pkg::ChkRepTail:   target = cfg_i.repeat_tail_us;
      necird_pkg::ChkBitMark:   target = cfg_i.bit_mark_us;
      necird_pkg::ChkOneSpace:  target = cfg_i.one_space_us;
      necird_pkg::ChkZeroSpace: target = cfg_i.zero_space_us;
      default:                  target = '0;
    endcase
  end

  // Even steps: upper bound, odd steps: lower bound (ignored when negative)
  assign factor = step_q[0]
    ? necird_pkg::FactorW'(necird_pkg::FactorW'(necird_pkg::Mille)
                           - necird_pkg::FactorW'(cfg_i.margin_per_mille))
    : necird_pkg::FactorW'(necird_pkg::FactorW'(necird_pkg::Mille)
                           + necird_pkg::FactorW'(cfg_i.margin_per_mille));

  always_comb begin
    case (necird_pkg::chk_e'(prev_chk))
      necird_pkg::ChkRepSpace,
      necird_pkg::ChkOneSpace,
      necird_pkg::ChkZeroSpace: scaled_sel = space_k_q;
      default:                  scaled_sel = mark_k_q;
    endcase
  end

  assign prod_ext = necird_pkg::ScaledW'(prod_q);
  assign cmp_ok   = prev_step[0] ? (margin_wide || (scaled_sel > prod_ext))
                                 : (scaled_sel < prod_ext);

  // Resolve the current pair against burst state
  assign idx     = pair_count_q;
  assign bit_idx = necird_pkg::ShiftIdxW'(idx - necird_pkg::PairCntW'(1));
  assign is_one  = !pair_q.mark_level && pair_q.space_level
                && win_q[necird_pkg::ChkBitMark] && win_q[necird_pkg::ChkOneSpace];
  assign is_bit  = !pair_q.mark_level && pair_q.space_level
                && win_q[necird_pkg::ChkBitMark]
                && (win_q[necird_pkg::ChkOneSpace] || win_q[necird_pkg::ChkZeroSpace]);

  always_comb begin
    shift_upd   = bit_shift_q;
    bit_err_upd = bit_err_q;
    hi_err_upd  = hi_err_q;
    rlb_upd     = rep_level_bad_q;
    rtb_upd     = rep_timing_bad_q;
    tail_bad    = 1'b0;
    if (idx == '0) begin
      rlb_upd = pair_q.mark_level && !pair_q.space_level;
      rtb_upd = !(win_q[necird_pkg::ChkRepMark] && win_q[necird_pkg::ChkRepSpace]);
    end else if (idx <= necird_pkg::PairCntW'(necird_pkg::ShiftW)) begin
      if (is_one) begin
        shift_upd[bit_idx] = 1'b1;
      end
      if (!is_bit) begin
        if (idx <= necird_pkg::PairCntW'(2 * necird_pkg::FieldW)) begin
          bit_err_upd = 1'b1;
        end else begin
          hi_err_upd = 1'b1;
        end
      end
      if (idx == necird_pkg::PairCntW'(1)) begin
        tail_bad = !win_q[necird_pkg::ChkRepTail];
      end
    end
    cnt_upd = (idx < necird_pkg::PairCntW'(necird_pkg::MaxPairs))
            ? idx + necird_pkg::PairCntW'(1) : idx;
  end

  always_comb begin
    result = '0;
    if (idx == necird_pkg::PairCntW'(necird_pkg::RepeatLen - 1)) begin
      if (rlb_upd) begin
        result.status = necird_pkg::StRepLevelErr;
      end else if (rtb_upd || tail_bad) begin
        result.status = necird_pkg::StRepTimingErr;
      end else begin
        result.status = necird_pkg::StRepeat;
      end
    end else if (idx == necird_pkg::PairCntW'(necird_pkg::FrameLen - 1)) begin
      if (bit_err_upd) begin
        result.status = necird_pkg::StBitErr;
      end else begin
        result.status  = necird_pkg::StFrame;
        result.address = shift_upd[necird_pkg::FieldW-1:0];
        result.command = shift_upd[2*necird_pkg::FieldW-1:necird_pkg::FieldW];
      end
    end else if (idx == necird_pkg::PairCntW'(necird_pkg::ExtLen - 1)) begin
      if (bit_err_upd || hi_err_upd) begin
        result.status = necird_pkg::StBitErr;
      end else begin
        result.status  = necird_pkg::StExtFrame;
        result.address = shift_upd[necird_pkg::FieldW-1:0];
        result.command = shift_upd[2*necird_pkg::FieldW-1:necird_pkg::FieldW];
        result.extra   = shift_upd[3*necird_pkg::FieldW-1:2*necird_pkg::FieldW];
      end
    end else begin
      result.status = necird_pkg::StBadLength;
    end
  end

  // A final pair waits for a free result register
  assign commit = (state_q == BDone) && !(pair_q.burst_end && out_valid_q && !out_ready_i);

  always_comb begin
    state_d          = state_q;
    pair_d           = pair_q;
    mark_k_d         = mark_k_q;
    space_k_d        = space_k_q;
    step_d           = step_q;
    prod_d           = prod_q;
    win_d            = win_q;
    pair_count_d     = pair_count_q;
    bit_shift_d      = bit_shift_q;
    bit_err_d        = bit_err_q;
    hi_err_d         = hi_err_q;
    rep_level_bad_d  = rep_level_bad_q;
    rep_timing_bad_d = rep_timing_bad_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    out_item_d       = out_item_q;
    pop_o            = 1'b0;
    case (state_q)
      BIdle: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          pair_d    = pop_data_i;
          mark_k_d  = times_mille(pop_data_i.mark_us);
          space_k_d = times_mille(pop_data_i.space_us);
          step_d    = '0;
          win_d     = '1;
          state_d   = BCalc;
        end
      end
      BCalc: begin
        if (step_q != '0) begin
          win_d[prev_chk] = win_q[prev_chk] & cmp_ok;
        end
        if (step_q == necird_pkg::StepW'(necird_pkg::NumSteps)) begin
          state_d = BDone;
        end else begin
          prod_d = necird_pkg::ProdW'(target) * necird_pkg::ProdW'(factor);
          step_d = step_q + necird_pkg::StepW'(1);
        end
      end
      BDone: begin
        if (commit) begin
          state_d = BIdle;
          if (pair_q.burst_end) begin
            out_valid_d      = 1'b1;
            out_item_d       = result;
            pair_count_d     = '0;
            bit_shift_d      = '0;
            bit_err_d        = 1'b0;
            hi_err_d         = 1'b0;
            rep_level_bad_d  = 1'b0;
            rep_timing_bad_d = 1'b0;
          end else begin
            pair_count_d     = cnt_upd;
            bit_shift_d      = shift_upd;
            bit_err_d        = bit_err_upd;
            hi_err_d         = hi_err_upd;
            rep_level_bad_d  = rlb_upd;
            rep_timing_bad_d = rtb_upd;
          end
        end
      end
      default: begin
        state_d = BIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= BIdle;
      step_q           <= '0;
      pair_count_q     <= '0;
      bit_shift_q      <= '0;
      bit_err_q        <= 1'b0;
      hi_err_q         <= 1'b0;
      rep_level_bad_q  <= 1'b0;
      rep_timing_bad_q <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      step_q           <= step_d;
      pair_count_q     <= pair_count_d;
      bit_shift_q      <= bit_shift_d;
      bit_err_q        <= bit_err_d;
      hi_err_q         <= hi_err_d;
      rep_level_bad_q  <= rep_level_bad_d;
      rep_timing_bad_q <= rep_timing_bad_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q     <= pair_d;
    mark_k_q   <= mark_k_d;
    space_k_q  <= space_k_d;
    prod_q     <= prod_d;
    win_q      <= win_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_burst_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && pair_q.burst_end) |=> (pair_count_q == '0) && (bit_shift_q == '0))
    else $error("burst state not cleared after final pair");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BCalc) |-> (step_q <= necird_pkg::StepW'(necird_pkg::NumSteps)))
    else $error("check step out of range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == BDone) && $past(pair_q.burst_end))
    else $error("result raised without a final pair");
`endif

endmodule

>>> design/nec_ir_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Decodes bursts of received pulse pairs into repeat codes and frames.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i/in_ready_o, in_item_i): one pulse pair per
//  transaction, burst_end set on the last pair of a burst. Output channel
//  (out_valid_o/out_ready_i, out_item_o): one result transaction per burst,
//  nothing for the pairs before the last one.
//  Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at
//  once; write only while no pair is in flight.
//  Datapath: the front end converts ticks to us with a bit-serial divider, one
//  quotient bit per cycle, and takes a new pair only once the last is queued.
//  The back end computes 12 products per pair on one shared multiplier.
//  A two-entry queue separates the two halves; when the receiver stalls the
//  result register holds, the back end stops on the next final pair, and the
//  front end keeps taking pairs until the queue is full.
//  Reset clears burst state, drops any pending result and loads the default
//  NEC timings (10 ticks per 10 us, 20 % margin).
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  necird_pkg::in_item_t                 in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output necird_pkg::out_item_t                out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [necird_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [necird_pkg::CfgDataW-1:0]      cfg_data_i
);

  necird_pkg::cfg_t  cfg_q;
  necird_pkg::pair_t push_data, pop_data;
  logic              push, pop, full, empty;

  // Configuration registers, reset to standard NEC timing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_10us   <= necird_pkg::DivW'(10);
      cfg_q.margin_per_mille <= necird_pkg::MarginW'(200);
      cfg_q.bit_mark_us      <= necird_pkg::TimeW'(560);
      cfg_q.one_space_us     <= necird_pkg::TimeW'(1690);
      cfg_q.zero_space_us    <= necird_pkg::TimeW'(560);
      cfg_q.repeat_mark_us   <= necird_pkg::TimeW'(9000);
      cfg_q.repeat_space_us  <= necird_pkg::TimeW'(2250);
      cfg_q.repeat_tail_us   <= necird_pkg::TimeW'(560);
    end else if (cfg_we_i) begin
      case (necird_pkg::cfg_idx_e'(cfg_idx_i))
        necird_pkg::CfgTicks:     cfg_q.ticks_per_10us   <= cfg_data_i[necird_pkg::DivW-1:0];
        necird_pkg::CfgMargin:    cfg_q.margin_per_mille <= cfg_data_i[necird_pkg::MarginW-1:0];
        necird_pkg::CfgBitMark:   cfg_q.bit_mark_us      <= cfg_data_i;
        necird_pkg::CfgOneSpace:  cfg_q.one_space_us     <= cfg_data_i;
        necird_pkg::CfgZeroSpace: cfg_q.zero_space_us    <= cfg_data_i;
        necird_pkg::CfgRepMark:   cfg_q.repeat_mark_us   <= cfg_data_i;
        necird_pkg::CfgRepSpace:  cfg_q.repeat_space_us  <= cfg_data_i;
        necird_pkg::CfgRepTail:   cfg_q.repeat_tail_us   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: accept and convert durations
  necird_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .divisor_i   (cfg_q.ticks_per_10us),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  necird_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Back: window checks, burst tracking, result register
  necird_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Drives bursts of pulse pairs (repeat codes, frames, extended frames, odd
// lengths and line noise) under changing timing registers, predicts every
// decode result, and checks each result transaction against the prediction.
// ----------------------------------------------------------------------------
module tb;
  import necird_pkg::*;

  localparam int unsigned ClkHalf       = 4;     // 8 ns period
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned HoldCycles    = 500;   // long receiver hold-off
  localparam int unsigned SettleCycles  = 64;    // longer than the result latency
  localparam int unsigned WatchdogLimit = 5000;  // cycles with no transaction
  localparam int unsigned RandomItems   = 170;
  localparam int unsigned MaxReports    = 10;

  typedef enum logic [1:0] {
    BitZero,
    BitOne,
    BitBad
  } bit_kind_e;

  // --------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  nec_ir_frame_decoder_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder prediction: own copy of the timing registers and burst state
  // --------------------------------------------------------------------------
  cfg_t                timing;
  logic [PairCntW-1:0] burst_pairs;
  logic [ShiftW-1:0]   burst_bits;
  bit                  low_bit_err;     // bad data pair among pairs 1..32
  bit                  high_bit_err;    // bad data pair among pairs 33..48
  bit                  rep_level_bad;
  bit                  rep_timing_bad;
  out_item_t           pending_decodes[$];

  int unsigned mismatch_cnt  = 0;
  int unsigned items_sent    = 0;
  int unsigned stuck_cycles  = 0;
  bit          quiet         = 1'b0;  // no idling on either side
  bit          hold_req      = 1'b0;  // asks the receiver for a long hold-off

  function automatic cfg_t nec_defaults();
    cfg_t c;
    c.ticks_per_10us   = 8'd10;
    c.margin_per_mille = 10'd200;
    c.bit_mark_us      = 15'd560;
    c.one_space_us     = 15'd1690;
    c.zero_space_us    = 15'd560;
    c.repeat_mark_us   = 15'd9000;
    c.repeat_space_us  = 15'd2250;
    c.repeat_tail_us   = 15'd560;
    return c;
  endfunction

  function automatic void clear_burst();
    burst_pairs    = '0;
    burst_bits     = '0;
    low_bit_err    = 1'b0;
    high_bit_err   = 1'b0;
    rep_level_bad  = 1'b0;
    rep_timing_bad = 1'b0;
  endfunction

  // Tick count to microseconds; a zero divisor saturates to all ones
  function automatic int unsigned ticks_to_us(logic [TickW-1:0] t);
    if (timing.ticks_per_10us == '0) begin
      return (1 << UsW) - 1;
    end
    return (32'(t) * 10) / 32'(timing.ticks_per_10us);
  endfunction

  // Strict window check, cross-multiplied; lower bound goes negative for
  // margins above 1000
  function automatic bit in_window(int unsigned us, int unsigned tgt);
    longint scaled, upper, lower;
    scaled = longint'(us) * longint'(Mille);
    upper  = longint'(tgt) * (longint'(Mille) + longint'(timing.margin_per_mille));
    lower  = longint'(tgt) * (longint'(Mille) - longint'(timing.margin_per_mille));
    return (scaled < upper) && (scaled > lower);
  endfunction

  function automatic bit_kind_e classify_bit(in_item_t p, int unsigned mark_us,
                                             int unsigned space_us);
    if (p.mark_level || !p.space_level || !in_window(mark_us, timing.bit_mark_us)) begin
      return BitBad;
    end
    if (in_window(space_us, timing.one_space_us)) begin
      return BitOne;
    end
    if (in_window(space_us, timing.zero_space_us)) begin
      return BitZero;
    end
    return BitBad;
  endfunction

  // Advances the burst state by one accepted pair; a final pair queues the
  // expected decode
  function automatic void decode_pair(in_item_t p);
    int unsigned mark_us, space_us, idx;
    bit          tail_bad;
    bit_kind_e   kind;
    out_item_t   res;
    mark_us  = ticks_to_us(p.mark_ticks);
    space_us = ticks_to_us(p.space_ticks);
    idx      = burst_pairs;
    tail_bad = 1'b0;
    if (idx == 0) begin
      rep_level_bad  = p.mark_level && !p.space_level;
      rep_timing_bad = !in_window(mark_us, timing.repeat_mark_us) ||
                       !in_window(space_us, timing.repeat_space_us);
    end else if (idx <= ShiftW) begin
      kind = classify_bit(p, mark_us, space_us);
      if (kind == BitOne) begin
        burst_bits[idx-1] = 1'b1;
      end
      if (kind == BitBad) begin
        if (idx <= 2 * FieldW) begin
          low_bit_err = 1'b1;
        end else begin
          high_bit_err = 1'b1;
        end
      end
      if (idx == 1) begin
        tail_bad = !in_window(mark_us, timing.repeat_tail_us);
      end
    end
    if (!p.burst_end) begin
      if (burst_pairs < MaxPairs) begin
        burst_pairs++;
      end
      return;
    end
    res = '0;
    case (idx + 1)
      RepeatLen: begin
        if (rep_level_bad) begin
          res.status = StRepLevelErr;
        end else if (rep_timing_bad || tail_bad) begin
          res.status = StRepTimingErr;
        end else begin
          res.status = StRepeat;
        end
      end
      FrameLen: begin
        if (low_bit_err) begin
          res.status = StBitErr;
        end else begin
          res.status  = StFrame;
          res.address = burst_bits[FieldW-1:0];
          res.command = burst_bits[2*FieldW-1:FieldW];
        end
      end
      ExtLen: begin
        if (low_bit_err || high_bit_err) begin
          res.status = StBitErr;
        end else begin
          res.status  = StExtFrame;
          res.address = burst_bits[FieldW-1:0];
          res.command = burst_bits[2*FieldW-1:FieldW];
          res.extra   = burst_bits[3*FieldW-1:2*FieldW];
        end
      end
      default: res.status = StBadLength;
    endcase
    pending_decodes.push_back(res);
    clear_burst();
  endfunction

  // --------------------------------------------------------------------------
  // Pulse synthesis from the current timing registers
  // --------------------------------------------------------------------------
  // Smallest tick count whose converted duration reaches us
  function automatic logic [TickW-1:0] us_to_ticks(int unsigned us);
    longint t;
    if (timing.ticks_per_10us == '0) begin
      return TickW'($urandom);
    end
    t = (longint'(us) * longint'(timing.ticks_per_10us) + 9) / 10;
    if (t > 32767) begin
      t = 32767;
    end
    return TickW'(t);
  endfunction

  // Target with jitter well inside the tolerance window
  function automatic int unsigned near(int unsigned tgt);
    int unsigned jit;
    jit = (tgt * timing.margin_per_mille) / 4000;
    return tgt - jit + $urandom_range(0, 2 * jit);
  endfunction

  function automatic in_item_t pulse_pair(bit ml, int unsigned mark_us, bit sl,
                                          int unsigned space_us, bit last);
    in_item_t p;
    p.mark_level  = ml;
    p.mark_ticks  = us_to_ticks(near(mark_us));
    p.space_level = sl;
    p.space_ticks = us_to_ticks(near(space_us));
    p.burst_end   = last;
    return p;
  endfunction

  function automatic in_item_t noise_pair(bit last);
    in_item_t p;
    p.mark_level  = 1'($urandom);
    p.mark_ticks  = TickW'($urandom);
    p.space_level = 1'($urandom);
    p.space_ticks = TickW'($urandom);
    p.burst_end   = last;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one pair and holds it until accepted. Valid stays high afterwards
  // unless a gap is drawn, so back-to-back pairs never toggle valid.
  task automatic send_pair(in_item_t p);
    in_item  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_pair(p);
    items_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Lowers valid, lets every result drain, then waits out any pair still in
  // the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_repeat(bit level_bad, bit timing_bad, bit tail_bad);
    int unsigned lead_mark, tail_mark;
    lead_mark = timing_bad ? timing.repeat_mark_us / 2 : timing.repeat_mark_us;
    tail_mark = tail_bad ? timing.repeat_tail_us * 3 : timing.repeat_tail_us;
    send_pair(pulse_pair(level_bad, lead_mark, !level_bad, timing.repeat_space_us, 1'b0));
    send_pair(pulse_pair(1'b0, tail_mark, 1'b1, $urandom_range(0, 20000), 1'b1));
  endtask

  // Header, nbits data pairs (LSB first), trailer. bad_pos picks one data pair
  // to replace with line noise, 0 for none.
  task automatic send_frame(int unsigned nbits, logic [ShiftW-1:0] bits,
                            int unsigned bad_pos);
    int unsigned space;
    send_pair(pulse_pair(1'b0, 9000, 1'b1, 4500, 1'b0));
    for (int unsigned k = 1; k <= nbits; k++) begin
      if (k == bad_pos) begin
        send_pair(noise_pair(1'b0));
      end else begin
        space = (k <= ShiftW && bits[k-1]) ? timing.one_space_us : timing.zero_space_us;
        send_pair(pulse_pair(1'b0, timing.bit_mark_us, 1'b1, space, 1'b0));
      end
    end
    send_pair(pulse_pair(1'b0, timing.bit_mark_us, 1'b1, $urandom_range(0, 30000), 1'b1));
  endtask

  task automatic send_noise_burst(int unsigned n);
    for (int unsigned k = 1; k < n; k++) begin
      send_pair(noise_pair(1'b0));
    end
    send_pair(noise_pair(1'b1));
  endtask

  function automatic logic [ShiftW-1:0] random_bits();
    return ShiftW'({$urandom, $urandom});
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CfgTicks:     timing.ticks_per_10us   = data[DivW-1:0];
      CfgMargin:    timing.margin_per_mille = data[MarginW-1:0];
      CfgBitMark:   timing.bit_mark_us      = data[TimeW-1:0];
      CfgOneSpace:  timing.one_space_us     = data[TimeW-1:0];
      CfgZeroSpace: timing.zero_space_us    = data[TimeW-1:0];
      CfgRepMark:   timing.repeat_mark_us   = data[TimeW-1:0];
      CfgRepSpace:  timing.repeat_space_us  = data[TimeW-1:0];
      CfgRepTail:   timing.repeat_tail_us   = data[TimeW-1:0];
      default: ;
    endcase
  endtask

  // Writes all eight registers once the decoder is idle; unused upper data
  // bits of the narrow registers carry junk
  task automatic load_timings(cfg_t c);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    settle();
    write_reg(CfgTicks, {junk[CfgDataW-1:DivW], c.ticks_per_10us});
    write_reg(CfgMargin, {junk[CfgDataW-1:MarginW], c.margin_per_mille});
    write_reg(CfgBitMark, c.bit_mark_us);
    write_reg(CfgOneSpace, c.one_space_us);
    write_reg(CfgZeroSpace, c.zero_space_us);
    write_reg(CfgRepMark, c.repeat_mark_us);
    write_reg(CfgRepSpace, c.repeat_space_us);
    write_reg(CfgRepTail, c.repeat_tail_us);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t random_timings();
    cfg_t c;
    c.ticks_per_10us   = 8'($urandom_range(1, 30));
    c.margin_per_mille = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 999))
                                                     : 10'($urandom_range(50, 400));
    c.bit_mark_us      = 15'($urandom_range(100, 1500));
    c.one_space_us     = 15'($urandom_range(800, 3000));
    c.zero_space_us    = 15'($urandom_range(100, 1500));
    c.repeat_mark_us   = 15'($urandom_range(2000, 10000));
    c.repeat_space_us  = 15'($urandom_range(500, 5000));
    c.repeat_tail_us   = 15'($urandom_range(100, 1500));
    return c;
  endfunction

  // One burst of the random mix: mostly well-formed codes with random
  // content, the rest corrupted frames, odd lengths and noise
  task automatic random_burst();
    int unsigned pick, nbits;
    pick  = $urandom_range(0, 99);
    nbits = $urandom_range(0, 1) ? 2 * FieldW : ShiftW;
    if (pick < 35) begin
      send_repeat($urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                  $urandom_range(0, 9) == 0);
    end else if (pick < 60) begin
      send_frame(2 * FieldW, random_bits(), 0);
    end else if (pick < 72) begin
      send_frame(ShiftW, random_bits(), 0);
    end else if (pick < 82) begin
      send_frame(nbits, random_bits(), $urandom_range(1, nbits));
    end else if (pick < 92) begin
      send_noise_burst($urandom_range(1, 8));
    end else begin
      send_frame($urandom_range(0, 40), random_bits(), 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Good repeat, level error (checked before timing), bad leader, bad tail
  task automatic test_repeat_codes();
    send_repeat(1'b0, 1'b0, 1'b0);
    send_repeat(1'b1, 1'b1, 1'b0);
    send_repeat(1'b0, 1'b1, 1'b0);
    send_repeat(1'b0, 1'b0, 1'b1);
    settle();
  endtask

  // One-pair bursts at both field extremes and a three-pair burst
  task automatic test_short_bursts();
    send_pair('1);
    send_pair(in_item_t'(1));
    send_noise_burst(3);
    settle();
  endtask

  // Zero and largest divisor, zero and largest margin, targets at both ends
  task automatic test_timing_extremes();
    cfg_t     c;
    in_item_t p;
    c = nec_defaults();
    c.ticks_per_10us   = '0;
    c.margin_per_mille = 10'd1023;
    load_timings(c);
    send_repeat(1'b0, 1'b0, 1'b0);
    send_pair(noise_pair(1'b1));

    c.ticks_per_10us   = 8'd255;
    c.margin_per_mille = '0;
    c.bit_mark_us      = '1;
    c.one_space_us     = '1;
    c.zero_space_us    = '1;
    c.repeat_mark_us   = '1;
    c.repeat_space_us  = '1;
    c.repeat_tail_us   = '1;
    load_timings(c);
    send_repeat(1'b0, 1'b0, 1'b0);

    c = '0;
    c.ticks_per_10us   = 8'd1;
    c.margin_per_mille = 10'd999;
    load_timings(c);
    send_repeat(1'b0, 1'b0, 1'b0);

    // Margin above 1000: zero-length pulses clear the negative lower bound
    c = nec_defaults();
    c.margin_per_mille = 10'd1023;
    load_timings(c);
    p = '0;
    p.space_level = 1'b1;
    send_pair(p);
    p.space_ticks = TickW'($urandom);
    p.burst_end   = 1'b1;
    send_pair(p);
    load_timings(nec_defaults());
  endtask

  task automatic test_frames();
    send_frame(2 * FieldW, {16'h0000, 16'h0000, 16'hffff}, 0);
    send_frame(2 * FieldW, random_bits(), 2 * FieldW);
    settle();
  endtask

  task automatic test_extended_frames();
    logic [ShiftW-1:0] low_bits;
    low_bits = random_bits();
    send_frame(ShiftW, {16'hffff, low_bits[2*FieldW-1:0]}, 0);
    send_frame(ShiftW, random_bits(), 40);
    settle();
  endtask

  // Lengths next to the frame lengths, and one burst longer than the pair counter limit
  task automatic test_burst_lengths();
    send_frame(FrameLen - 3, random_bits(), 0);
    send_frame(ExtLen - 1, random_bits(), 0);
    send_frame(MaxPairs + 5, random_bits(), 0);
    settle();
  endtask

  // Receiver holds off for a long stretch while repeats keep coming, so the
  // internal queue fills and the input stalls
  task automatic test_backpressure();
    settle();
    hold_req = 1'b1;
    repeat (8) send_repeat(1'b0, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned start_items;
    for (int phase = 0; phase < 3; phase++) begin
      load_timings(phase == 0 ? nec_defaults() : random_timings());
      start_items = items_sent;
      while (items_sent - start_items < RandomItems / 3) begin
        random_burst();
      end
    end
    settle();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    load_timings(random_timings());
    repeat (6) random_burst();
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("[%0t] unexpected result: status %0d address %h command %h extra %h",
                   $realtime, out_item.status, out_item.address, out_item.command,
                   out_item.extra);
        end
      end else begin
        want = pending_decodes.pop_front();
        if (out_item.status !== want.status || out_item.address !== want.address ||
            out_item.command !== want.command || out_item.extra !== want.extra) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("[%0t] mismatch (got/exp): status %0d/%0d address %h/%h",
                     $realtime, out_item.status, want.status, out_item.address,
                     want.address);
            $display("  command %h/%h extra %h/%h", out_item.command, want.command,
                     out_item.extra, want.extra);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WatchdogLimit) begin
          $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                   stuck_cycles, pending_decodes.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    timing = nec_defaults();
    clear_burst();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_repeat_codes();
    test_short_bursts();
    test_timing_extremes();
    test_frames();
    test_extended_frames();
    test_burst_lengths();
    test_backpressure();
    test_random_traffic();
    test_no_idle();

    if (pending_decodes.size() != 0) begin
      $display("%0d expected results never arrived", pending_decodes.size());
    end
    if (mismatch_cnt == 0 && pending_decodes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/necird_pkg.sv
design/necird_front.sv
design/necird_fifo.sv
design/necird_back.sv
design/nec_ir_frame_decoder_unit.sv
tb/tb.sv
